// File: hdl/hed_pkg.sv
package hed_pkg;

  // character codes that steer the tag parser
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChNul   = 8'h00;

  typedef struct packed {
    logic [7:0] ch;
    logic       new_batch;
  } in_t;

  typedef struct packed {
    logic [5:0] slot;
    logic [7:0] tag_char;
    logic       char_valid;
    logic [4:0] position;
    logic       dict_full;
    logic       truncated;
    logic       last;
  } out_t;

endpackage

// File: hdl/hed_dict_mem.sv
module hed_dict_mem import hed_pkg::*; #(
  parameter int Depth = 64,
  parameter int RowW  = 256,
  parameter int LenW  = 6,
  parameter int IdxW  = 6
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  logic [RowW-1:0] wrow_i,
  input  logic [LenW-1:0] wlen_i,
  input  logic [IdxW-1:0] raddr_i,
  output logic [RowW-1:0] rrow_o,
  output logic [LenW-1:0] rlen_o
);

  logic [RowW-1:0] row_mem [Depth];
  logic [LenW-1:0] len_mem [Depth];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      row_mem[waddr_i] <= wrow_i;
      len_mem[waddr_i] <= wlen_i;
    end
    rrow_o <= row_mem[raddr_i];
    rlen_o <= len_mem[raddr_i];
  end

endmodule

// File: hdl/hed_cmp.sv
module hed_cmp import hed_pkg::*; #(
  parameter int MaxLen = 32,
  parameter int LenW   = 6
) (
  input  logic [MaxLen*8-1:0] entry_row_i,
  input  logic [LenW-1:0]     entry_len_i,
  input  logic [MaxLen*8-1:0] tag_row_i,
  input  logic [LenW-1:0]     tag_len_i,
  output logic                eq_o
);

  logic [MaxLen-1:0] byte_ok;

  // bytes past the tag length are don't care
  always_comb begin
    for (int i = 0; i < MaxLen; i++) begin
      byte_ok[i] = (LenW'(i) >= tag_len_i) ||
                   (entry_row_i[i*8 +: 8] == tag_row_i[i*8 +: 8]);
    end
    eq_o = (entry_len_i == tag_len_i) && (&byte_ok);
  end

endmodule

// File: hdl/hashtag_extract_dedupe_unit.sv
// flow: a byte that closes no tag needs no further work; a closing byte
//   walks the dictionary (N stored entries, at most DICT_DEPTH) and stops
//   early on a match with no result; otherwise it then emits one result
//   per cycle (up to MAX_TAG_LEN) unless the receiver stalls
// throughput: one transaction at a time
// reset: rst_ni is asynchronous, active low; empties the dictionary and tag state
module hashtag_extract_dedupe_unit import hed_pkg::*; #(
  parameter int DICT_DEPTH  = 64,
  parameter int MAX_TAG_LEN = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam int CntW    = $clog2(DICT_DEPTH + 1);
  localparam int IdxW    = (DICT_DEPTH > 1) ? $clog2(DICT_DEPTH) : 1;
  localparam int LenW    = $clog2(MAX_TAG_LEN + 1);
  localparam int BufIdxW = (MAX_TAG_LEN > 1) ? $clog2(MAX_TAG_LEN) : 1;
  localparam int RowW    = MAX_TAG_LEN * 8;

  // sequencer states
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  logic [1:0]      state_q, state_d;
  logic            in_tag_q, in_tag_d;
  logic [LenW-1:0] cur_len_q, cur_len_d;
  logic            cur_trunc_q, cur_trunc_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] scan_idx_q, scan_idx_d;
  logic            pend_q, pend_d;
  logic            full_q, full_d;
  logic [CntW-1:0] slot_q, slot_d;
  logic [LenW-1:0] pos_q, pos_d;
  logic            out_valid_q, out_valid_d;
  out_t            out_data_q, out_data_d;

  // tag buffer, written at the fill point and read at the emit point
  logic [7:0]      cur_buf_q [MAX_TAG_LEN];
  logic            buf_we;
  logic [RowW-1:0] cur_row;

  logic            in_acc;
  logic            issue;
  logic            hit;
  logic            mem_we;
  logic [RowW-1:0] ent_row;
  logic [LenW-1:0] ent_len;
  logic            cmp_eq;
  logic [CntW+5:0] slot_wide;
  logic [LenW+4:0] pos_wide;
  logic            out_free;
  logic            is_delim;

  assign in_stall_o  = (state_q != StIdle);
  assign in_acc      = in_valid_i && (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    for (int i = 0; i < MAX_TAG_LEN; i++) begin
      cur_row[i*8 +: 8] = cur_buf_q[i];
    end
  end

  // dictionary walk: one read issued per cycle, compared in the cycle after
  assign issue = (state_q == StScan) && (scan_idx_q < count_q);
  assign hit   = pend_q && cmp_eq;

  hed_dict_mem #(
    .Depth (DICT_DEPTH),
    .RowW  (RowW),
    .LenW  (LenW),
    .IdxW  (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[IdxW-1:0]),
    .wrow_i  (cur_row),
    .wlen_i  (cur_len_q),
    .raddr_i (scan_idx_q[IdxW-1:0]),
    .rrow_o  (ent_row),
    .rlen_o  (ent_len)
  );

  hed_cmp #(
    .MaxLen (MAX_TAG_LEN),
    .LenW   (LenW)
  ) u_cmp (
    .entry_row_i (ent_row),
    .entry_len_i (ent_len),
    .tag_row_i   (cur_row),
    .tag_len_i   (cur_len_q),
    .eq_o        (cmp_eq)
  );

  // slot and position are reported in their low bits
  assign slot_wide = {6'd0, slot_q};
  assign pos_wide  = {5'd0, pos_q};

  always_comb begin
    state_d     = state_q;
    in_tag_d    = in_tag_q;
    cur_len_d   = cur_len_q;
    cur_trunc_d = cur_trunc_q;
    count_d     = count_q;
    scan_idx_d  = scan_idx_q;
    pend_d      = 1'b0;
    full_d      = full_q;
    slot_d      = slot_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    buf_we      = 1'b0;
    mem_we      = 1'b0;
    is_delim    = in_data_i.ch inside {ChHash, ChSpace, ChNul};

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (in_data_i.new_batch) begin
            count_d = '0;
          end
          if (is_delim) begin
            in_tag_d = (in_data_i.ch == ChHash);
            if (in_tag_q && !in_data_i.new_batch) begin
              // closed tag stays in the buffer for the walk
              state_d    = StScan;
              scan_idx_d = '0;
            end else begin
              cur_len_d   = '0;
              cur_trunc_d = 1'b0;
            end
          end else if (in_data_i.new_batch) begin
            in_tag_d    = 1'b0;
            cur_len_d   = '0;
            cur_trunc_d = 1'b0;
          end else if (in_tag_q) begin
            if (cur_len_q < LenW'(MAX_TAG_LEN)) begin
              buf_we    = 1'b1;
              cur_len_d = cur_len_q + 1'b1;
            end else begin
              cur_trunc_d = 1'b1;
            end
          end
        end
      end
      StScan: begin
        pend_d = issue;
        if (issue) begin
          scan_idx_d = scan_idx_q + 1'b1;
        end
        if (hit) begin
          // known tag, nothing to report
          state_d     = StIdle;
          pend_d      = 1'b0;
          cur_len_d   = '0;
          cur_trunc_d = 1'b0;
        end else if (!issue && !pend_q) begin
          state_d = StEmit;
          pos_d   = '0;
          slot_d  = count_q;
          if (count_q >= CntW'(DICT_DEPTH)) begin
            full_d = 1'b1;
          end else begin
            mem_we  = 1'b1;
            count_d = count_q + 1'b1;
          end
        end
      end
      StEmit: begin
        if (out_free) begin
          out_valid_d           = 1'b1;
          out_data_d.truncated  = cur_trunc_q;
          out_data_d.dict_full  = full_q;
          if (full_q || (cur_len_q == '0)) begin
            // single result: dropped tag or empty tag
            out_data_d.slot       = full_q ? 6'd0 : slot_wide[5:0];
            out_data_d.tag_char   = 8'd0;
            out_data_d.char_valid = 1'b0;
            out_data_d.position   = 5'd0;
            out_data_d.last       = 1'b1;
          end else begin
            out_data_d.slot       = slot_wide[5:0];
            out_data_d.tag_char   = cur_buf_q[pos_q[BufIdxW-1:0]];
            out_data_d.char_valid = 1'b1;
            out_data_d.position   = pos_wide[4:0];
            out_data_d.last       = ((pos_q + 1'b1) == cur_len_q);
          end
          if (full_q || (cur_len_q == '0) || ((pos_q + 1'b1) == cur_len_q)) begin
            state_d     = StIdle;
            full_d      = 1'b0;
            cur_len_d   = '0;
            cur_trunc_d = 1'b0;
          end else begin
            pos_d = pos_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      in_tag_q    <= 1'b0;
      cur_len_q   <= '0;
      cur_trunc_q <= 1'b0;
      count_q     <= '0;
      scan_idx_q  <= '0;
      pend_q      <= 1'b0;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_tag_q    <= in_tag_d;
      cur_len_q   <= cur_len_d;
      cur_trunc_q <= cur_trunc_d;
      count_q     <= count_d;
      scan_idx_q  <= scan_idx_d;
      pend_q      <= pend_d;
      full_q      <= full_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    slot_q     <= slot_d;
    pos_q      <= pos_d;
    out_data_q <= out_data_d;
    if (buf_we) begin
      cur_buf_q[cur_len_q[BufIdxW-1:0]] <= in_data_i.ch;
    end
  end

endmodule

// File: hdl/hed_checker.sv
module hed_checker import hed_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input in_t  in_data_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  // a stalled input transaction holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("stalled input changed");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // a run continues only through real characters
  a_run_chars: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> out_data_o.char_valid && !out_data_o.dict_full)
    else $error("non-final result without a character");

  // a dropped tag gives one bare result
  a_full_bare: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.dict_full |->
      out_data_o.last && !out_data_o.char_valid && (out_data_o.position == 5'd0)
      && (out_data_o.slot == 6'd0) && (out_data_o.tag_char == 8'd0))
    else $error("malformed dictionary full result");

  // no input is taken while a run is still being emitted
  a_busy_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> in_stall_o)
    else $error("input taken in the middle of a run");

endmodule

bind hashtag_extract_dedupe_unit hed_checker u_hed_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
